>>> rtl/imc_pkg.sv
// ----------------------------------------------------------------------------
// imc_pkg
// Shared types and constants of the impulse meter counter: transaction
// payloads, request and report codes, register indexes and divider widths.
// ----------------------------------------------------------------------------
package imc_pkg;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_IMPULSE  = 2'd0;
    localparam logic [1:0] REQ_PERIODIC = 2'd1;
    localparam logic [1:0] REQ_PRESET   = 2'd2;

    // Report codes on the output channel.
    localparam logic [1:0] KIND_IMPULSE  = 2'd0;
    localparam logic [1:0] KIND_PERIODIC = 2'd1;
    localparam logic [1:0] KIND_PRESET   = 2'd2;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS_PER_TICK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT_PER_TICK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS_PER_MS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT_PER_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LIMIT_S      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS         = 3'd5;

    // Time and scaling constants.
    localparam logic [31:0] MS_PER_S       = 32'd1000;
    localparam logic [25:0] MS_PER_S_NUM   = 26'd1000;
    localparam logic [31:0] PRESET_LAST_MS = 32'h7FFF_FFFF;
    localparam logic [4:0]  TICKS_MAX      = 5'd31;

    // Power divider: numerator is units_per_ms * 1000 in Q.16, below 2^42.
    localparam int NUM_W     = 42;
    localparam int DEN_W     = 32;
    localparam int DIV_CNT_W = 6;
    localparam int POWER_W   = 48;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] edge_time_ms;
        logic [31:0] now_ms;
        logic        pin_level;
        logic [31:0] preset_value;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic [1:0]         report_kind;
        logic [31:0]        abs_count;
        logic [47:0]        counter_mantissa;
        logic [POWER_W-1:0] power_mantissa;
        logic               power_saturated;
        logic               idle;
        logic [4:0]         window_ticks;
        logic [19:0]        window_mantissa;
    } t_out_item;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

>>> rtl/impulse_meter_counter.sv
// ----------------------------------------------------------------------------
// impulse_meter_counter
// Meter impulse counter with power estimate and recent-impulse window.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) carries one request per
// transaction: an impulse event, a periodic report or a preset of the count.
// Output channel (o_out_valid / i_out_stall / o_out_item) returns at most one
// report per request. Rejected impulses (pin high) and request code 3 return
// nothing. Configuration is written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata; write it only while the block is idle, which the block itself
// does not enforce. The block works on one request at a time. A preset or an
// impulse that needs no division passes S_MUL to S_EMIT; an impulse
// whose power needs a division waits in S_DIV for the 42-step divider, and a
// periodic report waits in S_SCAN for the scan of the ring memory through its
// single read port. The output register lets the next request be accepted
// while a report waits on a stalled receiver; the block then holds the
// following report until the register frees up.
// Synchronous reset clears the count, ring pointer, ring valid bits and loads
// the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module impulse_meter_counter
    import imc_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]   r_state;
    logic [2:0]   n_state;

    // Configuration registers.
    logic [15:0]  r_units_per_tick;
    logic [15:0]  r_units_per_ms;
    logic [15:0]  r_zero_limit_s;
    logic [31:0]  r_window_ms;

    // Counter state.
    logic [31:0]  r_count;
    logic [31:0]  r_last_counted;
    logic [31:0]  r_last_edge;
    logic [AW-1:0] r_ptr;

    // Per-request working registers.
    logic [1:0]         r_kind;
    logic [47:0]        r_cmant;
    logic [POWER_W-1:0] r_power;
    logic               r_sat;
    logic               r_idle;
    logic [31:0]        r_start;
    logic [AW:0]        r_scan_idx;
    logic [CNT_W-1:0]   r_scan_cnt;
    logic               r_cmp_v;

    // Output register.
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic        w_accept;
    logic        w_count_evt;
    logic [31:0] w_limit;
    logic [31:0] w_interval;
    logic        w_over;
    logic        w_zero;
    logic [25:0] w_num_int;
    logic        w_rd_en;
    logic [31:0] w_rd_data;
    logic        w_out_free;
    logic [4:0]  w_ticks;
    logic [20:0] w_wmant;
    logic [47:0] w_cmant;

    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;

    // Handshake and request decode.
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_count_evt = w_accept && (i_in_item.req_type == REQ_IMPULSE)
                         && !i_in_item.pin_level;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Interval tests and divider operands.
    assign w_limit    = 32'(r_zero_limit_s) * MS_PER_S;
    assign w_interval = i_in_item.edge_time_ms - r_last_counted;
    assign w_over     = (w_interval > w_limit);
    assign w_zero     = (w_interval == '0);
    assign w_num_int  = 26'(r_units_per_ms) * MS_PER_S_NUM;

    assign w_div_req.start = w_count_evt && !w_over && !w_zero;
    assign w_div_req.num   = {w_num_int, 16'd0};
    assign w_div_req.den   = w_interval;

    imc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Ring memory: written when an impulse is counted, read by the scan.
    assign w_rd_en = (r_state == S_SCAN) && (r_scan_idx < (AW+1)'(RING_DEPTH));

    imc_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_count_evt),
        .i_wr_addr (r_ptr),
        .i_wr_data (i_in_item.edge_time_ms),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_scan_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Configuration writes; the exponent registers only matter downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_units_per_tick <= 16'd1;
            r_units_per_ms   <= 16'd1;
            r_zero_limit_s   <= 16'd60;
            r_window_ms      <= 32'd60000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNITS_PER_TICK: r_units_per_tick <= i_cfg_wdata[15:0];
                CFG_UNITS_PER_MS:   r_units_per_ms   <= i_cfg_wdata[15:0];
                CFG_ZERO_LIMIT_S:   r_zero_limit_s   <= i_cfg_wdata[15:0];
                CFG_WINDOW_MS:      r_window_ms      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.req_type)
                        REQ_IMPULSE: begin
                            if (!i_in_item.pin_level) begin
                                n_state = w_div_req.start ? S_DIV : S_MUL;
                            end
                        end
                        REQ_PERIODIC: n_state = S_SCAN;
                        REQ_PRESET:   n_state = S_MUL;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL:  n_state = S_EMIT;
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (!w_rd_en && !r_cmp_v) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Counter state, updated when a request is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_last_counted <= PRESET_LAST_MS;
            r_last_edge    <= '0;
            r_ptr          <= '0;
            r_cmp_v        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmp_v <= w_rd_en;
            if (w_accept && (i_in_item.req_type == REQ_IMPULSE)) begin
                r_last_edge <= i_in_item.edge_time_ms;
            end
            if (w_count_evt) begin
                r_count        <= r_count + 1'b1;
                r_last_counted <= i_in_item.edge_time_ms;
                r_ptr <= (r_ptr == AW'(RING_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
            end
            if (w_accept && (i_in_item.req_type == REQ_PRESET)) begin
                r_count        <= i_in_item.preset_value;
                r_last_counted <= PRESET_LAST_MS;
            end
        end
    end

    // Counter mantissa, registered in the cycle after the count.
    assign w_cmant = 48'(r_count) * 48'(r_units_per_tick);

    always_ff @(posedge i_clk) begin
        r_cmant <= w_cmant;
    end

    // Per-request working registers: power, idle test and window scan.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind     <= i_in_item.req_type;
            r_power    <= '0;
            r_sat      <= 1'b0;
            r_idle     <= ((w_limit + r_last_edge) < i_in_item.now_ms);
            r_start    <= i_in_item.now_ms - r_window_ms;
            r_scan_idx <= '0;
            r_scan_cnt <= '0;
            if (w_count_evt && !w_over && w_zero) begin
                r_power <= '1;
                r_sat   <= 1'b1;
            end
        end else begin
            if ((r_state == S_DIV) && w_div_rsp.done) begin
                r_power <= POWER_W'(w_div_rsp.quo);
            end
            if (w_rd_en) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (r_cmp_v && (w_rd_data > r_start)) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
        end
    end

    // Window count, saturated to the field width.
    assign w_ticks = (32'(r_scan_cnt) > 32'(TICKS_MAX)) ? TICKS_MAX : 5'(r_scan_cnt);
    assign w_wmant = 21'(w_ticks) * 21'(r_units_per_tick);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out_item.report_kind      <= r_kind;
            r_out_item.abs_count        <= r_count;
            r_out_item.counter_mantissa <= r_cmant;
            r_out_item.power_mantissa   <= (r_kind == KIND_IMPULSE) ? r_power : '0;
            r_out_item.power_saturated  <= (r_kind == KIND_IMPULSE) && r_sat;
            r_out_item.idle             <= (r_kind == KIND_PERIODIC) && r_idle;
            r_out_item.window_ticks     <= (r_kind == KIND_PERIODIC) ? w_ticks : '0;
            r_out_item.window_mantissa  <= (r_kind == KIND_PERIODIC) ? w_wmant[19:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The divider only runs while the sequencer waits for it.
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.busy |-> (r_state == S_DIV))
        else $error("divider busy outside the divide state");

    // A new report appears only out of the emit state.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_EMIT))
        else $error("report loaded outside the emit state");

    // The scan never reads past the end of the ring.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_idx <= (AW+1)'(RING_DEPTH)))
        else $error("ring scan index beyond depth");

    // A report waiting on a stalled receiver is not overwritten.
    a_hold_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled report changed");

endmodule

>>> rtl/imc_div.sv
// ----------------------------------------------------------------------------
// imc_div
// Restoring radix-2 divider for the power estimate: one quotient bit per
// cycle until all NUM_W bits are in, one-cycle done pulse at the end.
// ----------------------------------------------------------------------------
module imc_div
    import imc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [NUM_W-1:0]     r_quo;

    logic [DEN_W:0]       w_shift;
    logic [DEN_W:0]       w_diff;
    logic                 w_fit;

    // Trial subtraction of the shifted partial remainder.
    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the numerator shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> rtl/imc_ring.sv
// ----------------------------------------------------------------------------
// imc_ring
// Ring of recent impulse times: one write port and one registered read port.
// Per-entry valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module imc_ring
    import imc_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data
);

    logic [31:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [31:0]      r_rd_q;
    logic             r_rd_hit;

    // Storage array and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // Valid bits, cleared by reset, and the valid bit of the entry read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_q : '0;

endmodule

>>> tb/tb_impulse_meter_counter.sv
// ----------------------------------------------------------------------------
// tb_impulse_meter_counter
// Self-checking testbench for the impulse meter counter. A short table of
// directed requests covers reset values, field extremes, every request code
// and the corner cases of the power and window logic. Phases of random
// requests under different register settings and handshake idling follow.
// Reports are compared field by field with typed table rows or a local model.
// ----------------------------------------------------------------------------
module tb_impulse_meter_counter
    import imc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS     = 16;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 100;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    // Request code that the block ignores, and register indexes it ignores.
    localparam logic [1:0]           REQ_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

    // One row of the directed table: a request and, where it is typed in,
    // the report it must produce.
    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Register mirror.
    logic [15:0] tick_units;
    logic [4:0]  tick_exp;
    logic [15:0] ms_units;
    logic [4:0]  ms_exp;
    logic [15:0] idle_limit_s;
    logic [31:0] window_len_ms;

    // Counter state mirror.
    logic [31:0] count_m;
    logic [31:0] prev_count_ms;
    logic [31:0] prev_edge_ms;
    logic [31:0] edge_ring [RING_SLOTS];
    int          ring_wr;

    // Reports still owed by the block, oldest first.
    t_out_item   pending_reports[$];
    t_script_row script[$];

    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    logic [31:0] cur_ms;
    t_out_item   got_want;

    impulse_meter_counter #(
        .RING_DEPTH(RING_SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Clock with a 20 ns period.
    always #10 i_clk = ~i_clk;

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    function automatic t_in_item mk_req(input logic [1:0] kind, input logic [31:0] edge_ms,
                                        input logic [31:0] now_ms, input logic pin,
                                        input logic [31:0] preset);
        t_in_item r;
        r.req_type     = kind;
        r.edge_time_ms = edge_ms;
        r.now_ms       = now_ms;
        r.pin_level    = pin;
        r.preset_value = preset;
        return r;
    endfunction

    function automatic t_out_item mk_rep(input logic [1:0] kind, input logic [31:0] cnt,
                                         input logic [47:0] counter, input logic [47:0] power,
                                         input logic sat, input logic idle_flag,
                                         input logic [4:0] ticks, input logic [19:0] wmant);
        t_out_item r;
        r.report_kind      = kind;
        r.abs_count        = cnt;
        r.counter_mantissa = counter;
        r.power_mantissa   = power;
        r.power_saturated  = sat;
        r.idle             = idle_flag;
        r.window_ticks     = ticks;
        r.window_mantissa  = wmant;
        return r;
    endfunction

    function automatic void add_row(input t_in_item req, input bit typed, input t_out_item want);
        t_script_row row;
        row.req   = req;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endfunction

    // Model of the counter: applies one accepted request and works out the
    // report it causes, if any.
    function automatic void predict_report(input t_in_item req, output bit has,
                                           output t_out_item rep);
        logic [31:0] gap_ms;
        logic [31:0] limit_ms;
        logic [31:0] deadline;
        logic [31:0] win_start;
        logic [31:0] wprod;
        logic [63:0] numer;
        logic [5:0]  hits;
        has = 1'b0;
        rep = '0;
        limit_ms = 32'(idle_limit_s) * MS_PER_S;
        case (req.req_type)
            REQ_IMPULSE: begin
                // The edge time is kept even when the pin is still high.
                prev_edge_ms = req.edge_time_ms;
                if (!req.pin_level) begin
                    has = 1'b1;
                    count_m = count_m + 32'd1;
                    gap_ms = req.edge_time_ms - prev_count_ms;
                    prev_count_ms = req.edge_time_ms;
                    edge_ring[ring_wr] = req.edge_time_ms;
                    ring_wr = (ring_wr >= RING_SLOTS - 1) ? 0 : ring_wr + 1;
                    rep.report_kind      = KIND_IMPULSE;
                    rep.abs_count        = count_m;
                    rep.counter_mantissa = 48'(64'(count_m) * 64'(tick_units));
                    if (gap_ms > limit_ms) begin
                        rep.power_mantissa = '0;
                    end else if (gap_ms == 32'd0) begin
                        rep.power_mantissa  = '1;
                        rep.power_saturated = 1'b1;
                    end else begin
                        numer = (64'(ms_units) * 64'(MS_PER_S)) << 16;
                        rep.power_mantissa = 48'(numer / 64'(gap_ms));
                    end
                end
            end
            REQ_PERIODIC: begin
                has = 1'b1;
                deadline  = limit_ms + prev_edge_ms;
                win_start = req.now_ms - window_len_ms;
                hits = '0;
                for (int i = 0; i < RING_SLOTS; i++) begin
                    if (edge_ring[i] > win_start) hits = hits + 6'd1;
                end
                if (hits > 6'(TICKS_MAX)) hits = 6'(TICKS_MAX);
                wprod = 32'(hits) * 32'(tick_units);
                rep.report_kind      = KIND_PERIODIC;
                rep.abs_count        = count_m;
                rep.counter_mantissa = 48'(64'(count_m) * 64'(tick_units));
                rep.idle             = (deadline < req.now_ms);
                rep.window_ticks     = hits[4:0];
                rep.window_mantissa  = wprod[19:0];
            end
            REQ_PRESET: begin
                has = 1'b1;
                count_m       = req.preset_value;
                prev_count_ms = PRESET_LAST_MS;
                rep.report_kind      = KIND_PRESET;
                rep.abs_count        = count_m;
                rep.counter_mantissa = 48'(64'(count_m) * 64'(tick_units));
            end
            default: begin
            end
        endcase
    endfunction

    // Interval between events: zero, short, around the idle limit, or any.
    function automatic logic [31:0] pick_gap();
        int unsigned r;
        logic [31:0] lim;
        r   = $urandom_range(99, 0);
        lim = 32'(idle_limit_s) * MS_PER_S;
        if (r < 4) return 32'd0;
        if (r < 60) return $urandom_range(3000, 1);
        if (r < 85) return $urandom_range(lim + lim / 4 + 1, 1);
        return $urandom;
    endfunction

    // Mostly a plausible meter stream, with some presets and noise.
    function automatic t_in_item random_request();
        t_in_item    r;
        int unsigned pick;
        logic [31:0] span;
        r = mk_req(2'($urandom), $urandom, $urandom, 1'($urandom), $urandom);
        pick = $urandom_range(99, 0);
        if (pick < 55) begin
            cur_ms = cur_ms + pick_gap();
            r.req_type     = REQ_IMPULSE;
            r.edge_time_ms = cur_ms;
            r.pin_level    = ($urandom_range(99, 0) < 15);
        end else if (pick < 80) begin
            span = (window_len_ms > 32'd200000) ? 32'd200000 : window_len_ms;
            r.req_type = REQ_PERIODIC;
            r.now_ms   = cur_ms + (($urandom_range(1, 0) == 0) ? pick_gap()
                                                               : $urandom_range(span, 0));
        end else if (pick < 88) begin
            r.req_type = REQ_PRESET;
            case ($urandom_range(3, 0))
                0: r.preset_value = 32'd0;
                1: r.preset_value = 32'hFFFF_FFFF;
                2: r.preset_value = 32'hFFFF_FFFF - $urandom_range(4, 0);
                default: r.preset_value = $urandom;
            endcase
        end else if (pick < 92) begin
            r.req_type = REQ_UNUSED;
        end
        return r;
    endfunction

    task automatic send_request(input t_in_item req, input bit typed, input t_out_item want);
        bit        has;
        t_out_item predicted;
        while ($urandom_range(99, 0) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        predict_report(req, has, predicted);
        if (has) pending_reports.push_back(typed ? want : predicted);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_UNITS_PER_TICK:    tick_units    = data[15:0];
            CFG_EXPONENT_PER_TICK: tick_exp      = data[4:0];
            CFG_UNITS_PER_MS:      ms_units      = data[15:0];
            CFG_EXPONENT_PER_MS:   ms_exp        = data[4:0];
            CFG_ZERO_LIMIT_S:      idle_limit_s  = data[15:0];
            CFG_WINDOW_MS:         window_len_ms = data;
            default: begin
            end
        endcase
    endtask

    // Writes every register; upper bits of the 16-bit ones carry noise.
    task automatic set_registers(input logic [15:0] upt, input int ept, input logic [15:0] upm,
                                 input int epm, input logic [15:0] zl, input logic [31:0] win);
        write_register(CFG_UNITS_PER_TICK, {16'($urandom), upt});
        write_register(CFG_EXPONENT_PER_TICK, 32'(ept));
        write_register(CFG_UNITS_PER_MS, {16'($urandom), upm});
        write_register(CFG_EXPONENT_PER_MS, 32'(epm));
        write_register(CFG_ZERO_LIMIT_S, {16'($urandom), zl});
        write_register(CFG_WINDOW_MS, win);
        write_register(CFG_UNUSED_6, $urandom);
        write_register(CFG_UNUSED_7, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // Waits for every owed report, then lets a rejected impulse finish.
    task automatic settle();
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic flag_field(input string field, input logic [63:0] want_v,
                              input logic [63:0] got_v);
        $display("%0t ns: %s expected %h, got %h", $time, field, want_v, got_v);
        mismatches++;
    endtask

    // Output monitor: every accepted transaction is checked against the
    // oldest owed report.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t ns: report expected none, got %h", $time, o_out_item);
                mismatches++;
            end else begin
                got_want = pending_reports.pop_front();
                if (o_out_item.report_kind !== got_want.report_kind)
                    flag_field("report_kind", got_want.report_kind, o_out_item.report_kind);
                if (o_out_item.abs_count !== got_want.abs_count)
                    flag_field("abs_count", got_want.abs_count, o_out_item.abs_count);
                if (o_out_item.counter_mantissa !== got_want.counter_mantissa)
                    flag_field("counter_mantissa", got_want.counter_mantissa,
                               o_out_item.counter_mantissa);
                if (o_out_item.power_mantissa !== got_want.power_mantissa)
                    flag_field("power_mantissa", got_want.power_mantissa,
                               o_out_item.power_mantissa);
                if (o_out_item.power_saturated !== got_want.power_saturated)
                    flag_field("power_saturated", got_want.power_saturated,
                               o_out_item.power_saturated);
                if (o_out_item.idle !== got_want.idle)
                    flag_field("idle", got_want.idle, o_out_item.idle);
                if (o_out_item.window_ticks !== got_want.window_ticks)
                    flag_field("window_ticks", got_want.window_ticks, o_out_item.window_ticks);
                if (o_out_item.window_mantissa !== got_want.window_mantissa)
                    flag_field("window_mantissa", got_want.window_mantissa,
                               o_out_item.window_mantissa);
            end
        end
    end

    // Watchdog: too long without any transaction ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("impulse_meter_counter: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item    req;
        int          counted;
        bit          paused_once;
        logic [31:0] all_ones;

        all_ones = 32'hFFFF_FFFF;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;

        // Model state after reset.
        tick_units    = 16'd1;
        tick_exp      = 5'd0;
        ms_units      = 16'd1;
        ms_exp        = 5'd0;
        idle_limit_s  = 16'd60;
        window_len_ms = 32'd60000;
        count_m       = '0;
        prev_count_ms = PRESET_LAST_MS;
        prev_edge_ms  = '0;
        ring_wr       = 0;
        foreach (edge_ring[i]) edge_ring[i] = '0;

        // Directed table, run with the reset register values.
        // Reports straight after reset, not idle and then idle.
        add_row(mk_req(REQ_PERIODIC, all_ones, 32'd0, 1'b0, all_ones), 1'b1,
                mk_rep(KIND_PERIODIC, 32'd0, 48'd0, 48'd0, 1'b0, 1'b0, 5'd0, 20'd0));
        add_row(mk_req(REQ_PERIODIC, 32'd0, all_ones, 1'b1, 32'd0), 1'b1,
                mk_rep(KIND_PERIODIC, 32'd0, 48'd0, 48'd0, 1'b0, 1'b1, 5'd0, 20'd0));
        // First edge at the preset time: zero interval saturates the power.
        add_row(mk_req(REQ_IMPULSE, 32'h7FFF_FFFF, all_ones, 1'b0, all_ones), 1'b1,
                mk_rep(KIND_IMPULSE, 32'd1, 48'd1, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 5'd0, 20'd0));
        // One second later: exactly one power unit in Q.16.
        add_row(mk_req(REQ_IMPULSE, 32'h8000_03E7, 32'd0, 1'b0, 32'd0), 1'b1,
                mk_rep(KIND_IMPULSE, 32'd2, 48'd2, 48'h1_0000, 1'b0, 1'b0, 5'd0, 20'd0));
        // Pin still high, then the unused request code: neither reports.
        add_row(mk_req(REQ_IMPULSE, all_ones, all_ones, 1'b1, all_ones), 1'b0, '0);
        add_row(mk_req(REQ_UNUSED, all_ones, all_ones, 1'b1, all_ones), 1'b0, '0);
        // Interval one past the idle limit, then exactly at it.
        add_row(mk_req(REQ_IMPULSE, 32'h8000_EE48, 32'd0, 1'b0, 32'd0), 1'b1,
                mk_rep(KIND_IMPULSE, 32'd3, 48'd3, 48'd0, 1'b0, 1'b0, 5'd0, 20'd0));
        add_row(mk_req(REQ_IMPULSE, 32'h8001_D8A8, 32'd0, 1'b0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_PERIODIC, 32'd0, 32'h8001_D8A8, 1'b0, 32'd0), 1'b0, '0);
        // Preset to the top, so that the next impulse wraps the count.
        add_row(mk_req(REQ_PRESET, 32'd0, 32'd0, 1'b0, all_ones), 1'b1,
                mk_rep(KIND_PRESET, all_ones, 48'h0000_FFFF_FFFF, 48'd0, 1'b0, 1'b0, 5'd0,
                       20'd0));
        add_row(mk_req(REQ_IMPULSE, 32'd0, 32'd0, 1'b0, 32'd0), 1'b1,
                mk_rep(KIND_IMPULSE, 32'd0, 48'd0, 48'd0, 1'b0, 1'b0, 5'd0, 20'd0));
        add_row(mk_req(REQ_PRESET, all_ones, all_ones, 1'b1, 32'd0), 1'b1,
                mk_rep(KIND_PRESET, 32'd0, 48'd0, 48'd0, 1'b0, 1'b0, 5'd0, 20'd0));
        // Edge times across the 32-bit wrap.
        add_row(mk_req(REQ_IMPULSE, all_ones, 32'd0, 1'b0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_IMPULSE, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_PERIODIC, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_PERIODIC, 32'd0, 32'h7FFF_FFFF, 1'b0, 32'd0), 1'b0, '0);
        add_row(mk_req(REQ_PRESET, 32'd0, 32'd0, 1'b0, 32'h8000_0000), 1'b1,
                mk_rep(KIND_PRESET, 32'h8000_0000, 48'h0000_8000_0000, 48'd0, 1'b0, 1'b0,
                       5'd0, 20'd0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) send_request(script[i].req, script[i].typed, script[i].want);
        i_in_valid <= 1'b0;

        // Random phases: register settings and idling change per phase.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            case (phase)
                0: set_registers(16'd1, 0, 16'd1, 0, 16'd60, 32'd60000);
                1: set_registers(16'hFFFF, -8, 16'hFFFF, 8, 16'd0, 32'd1);
                2: set_registers(16'd0, 8, 16'd0, -8, 16'hFFFF, 32'hFFFF_FFFF);
                default: set_registers(16'($urandom), int'($urandom_range(16, 0)) - 8,
                                       16'($urandom), int'($urandom_range(16, 0)) - 8,
                                       ($urandom_range(1, 0) == 0) ? 16'($urandom_range(120, 0))
                                                                   : 16'($urandom),
                                       ($urandom_range(3, 0) == 0)
                                           ? $urandom_range(32'hFFFF_FFFF, 1)
                                           : $urandom_range(200000, 1));
            endcase
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 80; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 80; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            cur_ms      = $urandom;
            counted     = 0;
            paused_once = 1'b0;
            while (counted < PHASE_ITEMS) begin
                // Once, the sender holds back until the block has drained.
                if (phase == 1 && counted == PHASE_ITEMS / 2 && !paused_once) begin
                    paused_once = 1'b1;
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_reports.size() != 0) @(posedge i_clk);
                end
                req = random_request();
                if (req.req_type != REQ_UNUSED) counted++;
                send_request(req, 1'b0, '0);
            end
            i_in_valid <= 1'b0;
        end

        settle();
        if (mismatches == 0) begin
            $display("impulse_meter_counter: match");
        end else begin
            $display("impulse_meter_counter: mismatch");
        end
        $finish;
    end

endmodule
